// ----- design/dsof_pkg.sv -----
package dsof_pkg;

   localparam int DAY_W    = 6;
   localparam int MONTH_W  = 4;
   localparam int YEAR_W   = 14;
   localparam int GRACE_W  = 8;
   localparam int RATE_W   = 16;
   localparam int SPAN_W   = 24;
   localparam int OVER_W   = 23;
   localparam int FINE_W   = 40;
   localparam int DNUM_W   = 23;
   localparam int CUM_W    = 9;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 16;

   localparam int DN_STAGES   = 3;
   localparam int FN_STAGES   = 2;
   localparam int PIPE_STAGES = DN_STAGES + FN_STAGES;

   localparam int DAYS_PER_YEAR = 365;
   localparam int MAX_DAY       = 31;
   localparam int MAX_MONTH     = 12;
   localparam int FEB           = 2;

   // floor(x / 25) as (x * mul) >> sh, exact over the ranges used
   localparam int DIV25_MUL  = 5243;
   localparam int DIV25_SH   = 17;
   localparam int Q4_DIV_MUL = 1311;
   localparam int Q4_DIV_SH  = 15;
   localparam int CENT_DIV   = 25;

   localparam int Q4_W   = YEAR_W - 2;
   localparam int P100P_W = Q4_W + 11;
   localparam int P100_W = 8;
   localparam int P400_W = P100_W - 2;
   localparam int P25P_W = YEAR_W + 13;
   localparam int Q25_W  = 10;

   localparam logic [GRACE_W-1:0] GRACE_RST = GRACE_W'(7);
   localparam logic [RATE_W-1:0]  RATE_RST  = RATE_W'(20);
   localparam logic [YEAR_W-1:0]  MINY_RST  = YEAR_W'(2000);

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_GRACE_DAYS   = 2'd0,
      CSR_FINE_PER_DAY = 2'd1,
      CSR_MIN_YEAR     = 2'd2,
      CSR_UNUSED       = 2'd3
   } csr_index_type;

   typedef struct packed {
      logic [DAY_W-1:0]   day;
      logic [MONTH_W-1:0] month;
      logic [YEAR_W-1:0]  year;
   } date_type;

   // days of the months before month m in a common year
   function automatic logic [CUM_W-1:0] cum_days(input logic [MONTH_W-1:0] m);
      logic [CUM_W-1:0] r;
      case (m)
         4'd0, 4'd1: r = CUM_W'(0);
         4'd2:  r = CUM_W'(31);
         4'd3:  r = CUM_W'(59);
         4'd4:  r = CUM_W'(90);
         4'd5:  r = CUM_W'(120);
         4'd6:  r = CUM_W'(151);
         4'd7:  r = CUM_W'(181);
         4'd8:  r = CUM_W'(212);
         4'd9:  r = CUM_W'(243);
         4'd10: r = CUM_W'(273);
         4'd11: r = CUM_W'(304);
         4'd12: r = CUM_W'(334);
         default: r = CUM_W'(0);
      endcase
      return r;
   endfunction

endpackage

// ----- design/dsof_req_if.sv -----
interface dsof_req_if;
   import dsof_pkg::*;

   logic               valid;
   logic               ready;
   logic [DAY_W-1:0]   start_day;
   logic [MONTH_W-1:0] start_month;
   logic [YEAR_W-1:0]  start_year;
   logic [DAY_W-1:0]   end_day;
   logic [MONTH_W-1:0] end_month;
   logic [YEAR_W-1:0]  end_year;

   modport source (
      output valid, start_day, start_month, start_year, end_day, end_month, end_year,
      input  ready
   );

   modport sink (
      input  valid, start_day, start_month, start_year, end_day, end_month, end_year,
      output ready
   );
endinterface

// ----- design/dsof_rsp_if.sv -----
interface dsof_rsp_if;
   import dsof_pkg::*;

   logic                     valid;
   logic                     ready;
   logic                     dates_valid;
   logic signed [SPAN_W-1:0] span_days;
   logic [OVER_W-1:0]        overdue_days;
   logic [FINE_W-1:0]        fine_amount;

   modport source (
      output valid, dates_valid, span_days, overdue_days, fine_amount,
      input  ready
   );

   modport sink (
      input  valid, dates_valid, span_days, overdue_days, fine_amount,
      output ready
   );
endinterface

// ----- design/date_span_overdue_fine_core.sv -----
// Date span and overdue fine: each item carries a start and an end Gregorian date; the
// block checks both (day at most 31, month at most 12, year at least min_year), turns
// each into a day number with the leap-year rule, and returns the signed span, the days
// beyond the grace period and the fine at the per-day rate. Invalid dates give
// dates_valid low and zero results. The block is a five-stage pipeline: three stages
// build the day numbers, one forms span and overdue days, one forms the fine product
// and holds the result. It takes one item per cycle while the output is not stalled, and
// each accepted item moves through the stage registers in order. Each stage holds an
// item until the next stage frees, so bubbles close up behind a stalled output. Register
// writes are meant for idle periods only.
module date_span_overdue_fine_core (
   input  logic                            clock,
   input  logic                            reset,
   dsof_req_if.sink                        req_ch,
   dsof_rsp_if.source                      rsp_ch,
   input  logic                            csr_we,
   input  logic [dsof_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [dsof_pkg::CSR_DATA_W-1:0] csr_wdata
);
   import dsof_pkg::*;

   // configuration registers
   logic [GRACE_W-1:0] grace_ff, grace_in;
   logic [RATE_W-1:0]  rate_ff, rate_in;
   logic [YEAR_W-1:0]  miny_ff, miny_in;

   always_comb begin
      grace_in = grace_ff;
      rate_in  = rate_ff;
      miny_in  = miny_ff;
      if (csr_we) begin
         case (csr_index_type'(csr_index))
            CSR_GRACE_DAYS:   grace_in = csr_wdata[GRACE_W-1:0];
            CSR_FINE_PER_DAY: rate_in  = csr_wdata[RATE_W-1:0];
            CSR_MIN_YEAR:     miny_in  = csr_wdata[YEAR_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         grace_ff <= GRACE_RST;
         rate_ff  <= RATE_RST;
         miny_ff  <= MINY_RST;
      end else begin
         grace_ff <= grace_in;
         rate_ff  <= rate_in;
         miny_ff  <= miny_in;
      end
   end

   // pipeline valid bits and per-stage ready
   logic [PIPE_STAGES-1:0] vld_ff, vld_in, rdy;

   always_comb begin
      rdy[PIPE_STAGES-1] = !vld_ff[PIPE_STAGES-1] || rsp_ch.ready;
      for (int i = PIPE_STAGES - 2; i >= 0; i--) begin
         rdy[i] = !vld_ff[i] || rdy[i+1];
      end
      for (int i = 0; i < PIPE_STAGES; i++) begin
         if (rdy[i]) begin
            vld_in[i] = (i == 0) ? req_ch.valid : vld_ff[(i == 0) ? 0 : i - 1];
         end else begin
            vld_in[i] = vld_ff[i];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   assign req_ch.ready = rdy[0];
   assign rsp_ch.valid = vld_ff[PIPE_STAGES-1];

   date_type            start_date, end_date;
   logic [DNUM_W-1:0]   start_num, end_num;
   logic                start_ok, end_ok;

   assign start_date = '{day: req_ch.start_day, month: req_ch.start_month,
                         year: req_ch.start_year};
   assign end_date   = '{day: req_ch.end_day, month: req_ch.end_month,
                         year: req_ch.end_year};

   dsof_day_num u_start_num (
      .clock    (clock),
      .ld       (rdy[DN_STAGES-1:0]),
      .date     (start_date),
      .min_year (miny_ff),
      .day_num  (start_num),
      .ok       (start_ok)
   );

   dsof_day_num u_end_num (
      .clock    (clock),
      .ld       (rdy[DN_STAGES-1:0]),
      .date     (end_date),
      .min_year (miny_ff),
      .day_num  (end_num),
      .ok       (end_ok)
   );

   dsof_fine u_fine (
      .clock        (clock),
      .ld           (rdy[PIPE_STAGES-1:DN_STAGES]),
      .start_num    (start_num),
      .end_num      (end_num),
      .dates_ok     (start_ok && end_ok),
      .grace_days   (grace_ff),
      .fine_per_day (rate_ff),
      .dates_valid  (rsp_ch.dates_valid),
      .span_days    (rsp_ch.span_days),
      .overdue_days (rsp_ch.overdue_days),
      .fine_amount  (rsp_ch.fine_amount)
   );

   a_accept_enters: assert property (@(posedge clock) disable iff (reset)
      req_ch.valid && req_ch.ready |=> vld_ff[0])
      else $error("accepted item did not enter the first stage");

   a_invalid_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_ch.valid && !rsp_ch.dates_valid |->
         rsp_ch.span_days == '0 && rsp_ch.overdue_days == '0 && rsp_ch.fine_amount == '0)
      else $error("invalid dates gave nonzero results");

   a_negative_no_fine: assert property (@(posedge clock) disable iff (reset)
      rsp_ch.valid && rsp_ch.span_days[SPAN_W-1] |->
         rsp_ch.overdue_days == '0 && rsp_ch.fine_amount == '0)
      else $error("negative span gave overdue days");

   a_stall_holds_stage: assert property (@(posedge clock) disable iff (reset)
      vld_ff[PIPE_STAGES-2] && !rdy[PIPE_STAGES-2] |=> vld_ff[PIPE_STAGES-2])
      else $error("stalled item dropped from stage four");

endmodule

// ----- design/dsof_day_num.sv -----
module dsof_day_num (
   input  logic                           clock,
   input  logic [dsof_pkg::DN_STAGES-1:0] ld,
   input  dsof_pkg::date_type             date,
   input  logic [dsof_pkg::YEAR_W-1:0]    min_year,
   output logic [dsof_pkg::DNUM_W-1:0]    day_num,
   output logic                           ok
);
   import dsof_pkg::*;

   // stage 1: range check and products
   logic [YEAR_W-1:0]  prev_year;
   logic [Q4_W-1:0]    q4;
   logic               ok1_in, ok1_ff;
   logic [YEAR_W-1:0]  year1_ff;
   logic [DAY_W-1:0]   day1_ff;
   logic [CUM_W-1:0]   cum1_in, cum1_ff;
   logic               m3_1_in, m3_1_ff;
   logic [DNUM_W-1:0]  y365_in, y365_ff;
   logic [Q4_W-1:0]    q4_ff;
   logic [P100P_W-1:0] p100p_in, p100p_ff;
   logic [P25P_W-1:0]  p25p_in, p25p_ff;

   always_comb begin
      prev_year = (date.year != '0) ? date.year - YEAR_W'(1) : '0;
      q4        = prev_year[YEAR_W-1:2];
      ok1_in    = (date.day <= DAY_W'(MAX_DAY)) && (date.month <= MONTH_W'(MAX_MONTH))
                  && (date.year >= min_year);
      cum1_in   = cum_days(date.month);
      m3_1_in   = date.month > MONTH_W'(FEB);
      y365_in   = DNUM_W'(prev_year) * DNUM_W'(DAYS_PER_YEAR);
      p100p_in  = P100P_W'(q4) * P100P_W'(Q4_DIV_MUL);
      p25p_in   = P25P_W'(date.year) * P25P_W'(DIV25_MUL);
   end

   always_ff @(posedge clock) begin
      if (ld[0]) begin
         ok1_ff   <= ok1_in;
         year1_ff <= date.year;
         day1_ff  <= date.day;
         cum1_ff  <= cum1_in;
         m3_1_ff  <= m3_1_in;
         y365_ff  <= y365_in;
         q4_ff    <= q4;
         p100p_ff <= p100p_in;
         p25p_ff  <= p25p_in;
      end
   end

   // stage 2: earlier-year days and century test
   logic [P100_W-1:0] p100;
   logic [P400_W-1:0] p400;
   logic [Q25_W-1:0]  q25;
   logic [DNUM_W-1:0] base2_in, base2_ff;
   logic [YEAR_W-1:0] mul25_in, mul25_ff;
   logic              ok2_ff, m3_2_ff;
   logic [YEAR_W-1:0] year2_ff;
   logic [DAY_W-1:0]  day2_ff;
   logic [CUM_W-1:0]  cum2_ff;

   always_comb begin
      p100     = P100_W'(p100p_ff >> Q4_DIV_SH);
      p400     = P400_W'(p100 >> 2);
      q25      = Q25_W'(p25p_ff >> DIV25_SH);
      base2_in = y365_ff + DNUM_W'(q4_ff) - DNUM_W'(p100) + DNUM_W'(p400);
      mul25_in = YEAR_W'(YEAR_W'(q25) * YEAR_W'(CENT_DIV));
   end

   always_ff @(posedge clock) begin
      if (ld[1]) begin
         base2_ff <= base2_in;
         mul25_ff <= mul25_in;
         ok2_ff   <= ok1_ff;
         m3_2_ff  <= m3_1_ff;
         year2_ff <= year1_ff;
         day2_ff  <= day1_ff;
         cum2_ff  <= cum1_ff;
      end
   end

   // stage 3: leap rule and final sum
   logic              by25, leap;
   logic [DNUM_W-1:0] dnum3_in, dnum3_ff;
   logic              ok3_ff;

   always_comb begin
      by25     = year2_ff == mul25_ff;
      leap     = ((year2_ff[1:0] == 2'd0) && !by25) || ((year2_ff[3:0] == 4'd0) && by25);
      dnum3_in = base2_ff + DNUM_W'(cum2_ff) + DNUM_W'(leap && m3_2_ff) + DNUM_W'(day2_ff);
   end

   always_ff @(posedge clock) begin
      if (ld[2]) begin
         dnum3_ff <= dnum3_in;
         ok3_ff   <= ok2_ff;
      end
   end

   assign day_num = dnum3_ff;
   assign ok      = ok3_ff;

endmodule

// ----- design/dsof_fine.sv -----
module dsof_fine (
   input  logic                                 clock,
   input  logic [dsof_pkg::FN_STAGES-1:0]       ld,
   input  logic [dsof_pkg::DNUM_W-1:0]          start_num,
   input  logic [dsof_pkg::DNUM_W-1:0]          end_num,
   input  logic                                 dates_ok,
   input  logic [dsof_pkg::GRACE_W-1:0]         grace_days,
   input  logic [dsof_pkg::RATE_W-1:0]          fine_per_day,
   output logic                                 dates_valid,
   output logic signed [dsof_pkg::SPAN_W-1:0]   span_days,
   output logic [dsof_pkg::OVER_W-1:0]          overdue_days,
   output logic [dsof_pkg::FINE_W-1:0]          fine_amount
);
   import dsof_pkg::*;

   // stage 4: span and days beyond grace
   logic signed [SPAN_W-1:0] span_raw, grace_ext, diff;
   logic signed [SPAN_W-1:0] span4_in, span4_ff;
   logic [OVER_W-1:0]        over4_in, over4_ff;
   logic                     ok4_ff;

   always_comb begin
      span_raw  = signed'(SPAN_W'(end_num)) - signed'(SPAN_W'(start_num));
      grace_ext = signed'(SPAN_W'(grace_days));
      diff      = span_raw - grace_ext;
      span4_in  = dates_ok ? span_raw : '0;
      over4_in  = (dates_ok && (span_raw >= grace_ext)) ? OVER_W'(diff) : '0;
   end

   always_ff @(posedge clock) begin
      if (ld[0]) begin
         ok4_ff   <= dates_ok;
         span4_ff <= span4_in;
         over4_ff <= over4_in;
      end
   end

   // stage 5: fine product, output register
   logic [FINE_W-1:0]        fine5_in, fine5_ff;
   logic                     ok5_ff;
   logic signed [SPAN_W-1:0] span5_ff;
   logic [OVER_W-1:0]        over5_ff;

   assign fine5_in = FINE_W'(FINE_W'(over4_ff) * FINE_W'(fine_per_day));

   always_ff @(posedge clock) begin
      if (ld[1]) begin
         ok5_ff   <= ok4_ff;
         span5_ff <= span4_ff;
         over5_ff <= over4_ff;
         fine5_ff <= fine5_in;
      end
   end

   assign dates_valid  = ok5_ff;
   assign span_days    = span5_ff;
   assign overdue_days = over5_ff;
   assign fine_amount  = fine5_ff;

endmodule
